### design/ihex_pkg.sv
// Shared types, constants and the hex digit decoder of the Intel HEX record parser.
`default_nettype none

package ihex_pkg;

  // Width of the running address pointer; any value from 20 to 64 works.
  localparam int ADDR_BITS = 32;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_MAX_RECORD_ADDRESS = 3'd0;
  localparam logic [15:0] MAX_RECORD_ADDRESS_RESET = 16'hFFFF;

  // Line length bookkeeping.
  localparam int CHAR_COUNT_W = 10;
  localparam logic [CHAR_COUNT_W-1:0] CHAR_COUNT_MAX = 10'd1023;
  localparam logic [CHAR_COUNT_W-1:0] HEADER_CHARS = 10'd10;

  // Record types with special handling.
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EXT_SEGMENT = 8'h02;
  localparam logic [7:0] REC_EXT_LINEAR = 8'h04;

  // Skipped prefix characters.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Bit positions of the bad-field flags.
  localparam int BAD_COUNT = 0;
  localparam int BAD_ADDR = 1;
  localparam int BAD_TYPE = 2;
  localparam int BAD_DATA = 3;
  localparam int BAD_CHK = 4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_JUMP     = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_line;
  } char_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [31:0] byte_address;
    logic [7:0]  byte_value;
    logic [7:0]  record_kind;
    status_t     status;
    logic        checksum_matches;
  } result_item_t;

  // Returns {bad, nibble}; a non-hex character decodes as nibble zero with bad set.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: character decoding, record state and result register.
`default_nettype none

// Channel   Handshake                    Payload          Direction
// -------   ---------------------------  ---------------  ---------
// char      char_valid / char_ready      char_item_t      into block
// result    result_valid / result_ready  result_item_t    out of block
// config    APB write/read, pready = 1   max_record_address at address 0
//
// Every character item is decoded in the cycle it is accepted; at most one result
// item appears in the result register on the following cycle, so the block takes
// one item per clock unless the result side stalls. The single result register is
// the only buffering: a new item is accepted whenever that register is empty or is
// being drained in the same cycle. Synchronous reset clears the pointer, the line
// state and the result valid flag and sets max_record_address to 0xFFFF.
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // character channel
  input  wire logic               char_valid,
  output logic                    char_ready,
  input  wire char_item_t         char_item,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_item_t            result_item,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // Configuration register.
  logic [15:0] max_record_address;

  // Address tracking, kept across lines.
  logic [ADDR_BITS-1:0] address_pointer, address_pointer_next;
  logic [ADDR_BITS-1:0] record_start, record_start_next;

  // Per-line state, cleared by every terminator item.
  logic [CHAR_COUNT_W-1:0] char_count, char_count_next;
  logic                    prefix_done, prefix_done_next;
  logic [3:0]              nibble_hold, nibble_hold_next;
  logic [7:0]              field_count, field_count_next;
  logic [15:0]             field_address, field_address_next;
  logic [7:0]              field_type, field_type_next;
  logic [7:0]              field_checksum, field_checksum_next;
  logic [7:0]              data_index, data_index_next;
  logic [31:0]             extended_value, extended_value_next;
  logic [7:0]              running_sum, running_sum_next;
  logic [4:0]              bad_field_flags, bad_field_flags_next;

  logic         accept;
  logic         emit;
  result_item_t result_next;

  // Working values of the decode.
  logic [8:0]              pair_index;
  logic [8:0]              checksum_pair;
  logic [4:0]              field_flag;
  logic [4:0]              decoded;
  logic [3:0]              nib;
  logic [7:0]              rx_byte;
  logic [CHAR_COUNT_W-1:0] full_length;
  logic [ADDR_BITS:0]      advanced;
  status_t                 line_status;
  logic [ADDR_BITS-1:0]    shown_address;
  logic                    sum_zero;

  assign char_ready = !result_valid || result_ready;
  assign accept     = char_valid && char_ready;
  assign pready     = 1'b1;

  // Register read: only max_record_address is defined.
  always_comb begin
    prdata = '0;
    if (paddr == REG_MAX_RECORD_ADDRESS) begin
      prdata = PDATA_W'(max_record_address);
    end
  end

  always_comb begin
    address_pointer_next = address_pointer;
    record_start_next    = record_start;
    char_count_next      = char_count;
    prefix_done_next     = prefix_done;
    nibble_hold_next     = nibble_hold;
    field_count_next     = field_count;
    field_address_next   = field_address;
    field_type_next      = field_type;
    field_checksum_next  = field_checksum;
    data_index_next      = data_index;
    extended_value_next  = extended_value;
    running_sum_next     = running_sum;
    bad_field_flags_next = bad_field_flags;
    emit                 = 1'b0;
    result_next          = '0;

    pair_index    = char_count[CHAR_COUNT_W-1:1];
    checksum_pair = 9'(field_count) + 9'd4;
    decoded       = hex_decode(char_item.character);
    nib           = decoded[3:0];
    rx_byte       = {nibble_hold, nib};
    full_length   = {1'b0, field_count, 1'b0} + HEADER_CHARS;
    advanced      = {1'b0, record_start} + (ADDR_BITS + 1)'(field_count);
    sum_zero      = (running_sum + field_checksum) == 8'h00;
    line_status   = STATUS_OK;
    shown_address = address_pointer;

    // Which field the current character belongs to.
    if (pair_index == 9'd0) begin
      field_flag = 5'(1 << BAD_COUNT);
    end else if (pair_index <= 9'd2) begin
      field_flag = 5'(1 << BAD_ADDR);
    end else if (pair_index == 9'd3) begin
      field_flag = 5'(1 << BAD_TYPE);
    end else if (pair_index < checksum_pair) begin
      field_flag = 5'(1 << BAD_DATA);
    end else begin
      field_flag = 5'(1 << BAD_CHK);
    end

    if (accept && char_item.end_of_line) begin
      // Close the record. The pointer low half is only replaced once the
      // header is long enough and its address field is clean.
      if (char_count < HEADER_CHARS || bad_field_flags[BAD_ADDR]) begin
        line_status = STATUS_MALFORMED;
      end else begin
        address_pointer_next = record_start;
        shown_address        = record_start;
        if (bad_field_flags[BAD_COUNT] || char_count < full_length) begin
          line_status = STATUS_MALFORMED;
        end else if (field_address > max_record_address) begin
          line_status = STATUS_JUMP;
        end else if (bad_field_flags[BAD_TYPE] || bad_field_flags[BAD_DATA]
                     || bad_field_flags[BAD_CHK]) begin
          line_status = STATUS_MALFORMED;
        end else if (field_type == REC_EXT_SEGMENT) begin
          address_pointer_next = ADDR_BITS'(64'({extended_value, 4'h0}));
        end else if (field_type == REC_EXT_LINEAR) begin
          address_pointer_next = ADDR_BITS'(64'({extended_value, 16'h0000}));
        end else if (advanced[ADDR_BITS]) begin
          line_status = STATUS_OVERFLOW;
        end else begin
          address_pointer_next = advanced[ADDR_BITS-1:0];
        end
      end
      emit                         = 1'b1;
      result_next.kind             = KIND_STATUS;
      result_next.byte_address     = 32'(shown_address);
      result_next.byte_value       = '0;
      result_next.record_kind      = field_type;
      result_next.status           = line_status;
      result_next.checksum_matches = (char_count >= full_length) && sum_zero;

      char_count_next      = '0;
      prefix_done_next     = 1'b0;
      nibble_hold_next     = '0;
      field_count_next     = '0;
      field_address_next   = '0;
      field_type_next      = '0;
      field_checksum_next  = '0;
      data_index_next      = '0;
      extended_value_next  = '0;
      running_sum_next     = '0;
      bad_field_flags_next = '0;
    end else if (accept && (prefix_done || !(char_item.character == CHAR_SPACE
                 || char_item.character == CHAR_TAB
                 || char_item.character == CHAR_COLON))) begin
      prefix_done_next = 1'b1;
      if (char_count != CHAR_COUNT_MAX) begin
        char_count_next = char_count + CHAR_COUNT_W'(1);
      end
      // Characters past the checksum are ignored.
      if (pair_index <= checksum_pair) begin
        if (decoded[4]) begin
          bad_field_flags_next = bad_field_flags | field_flag;
        end
        if (!char_count[0]) begin
          nibble_hold_next = nib;
        end else begin
          if (!field_flag[BAD_CHK]) begin
            running_sum_next = running_sum + rx_byte;
          end
          if (field_flag[BAD_COUNT]) begin
            field_count_next = rx_byte;
          end else if (field_flag[BAD_ADDR]) begin
            field_address_next = {field_address[7:0], rx_byte};
            if (pair_index == 9'd2) begin
              record_start_next = {address_pointer[ADDR_BITS-1:16], field_address[7:0],
                                   rx_byte};
            end
          end else if (field_flag[BAD_TYPE]) begin
            field_type_next = rx_byte;
          end else if (field_flag[BAD_DATA]) begin
            data_index_next     = data_index + 8'd1;
            extended_value_next = {extended_value[23:0], rx_byte};
            if (field_type == REC_DATA) begin
              emit                     = 1'b1;
              result_next.kind         = KIND_DATA;
              result_next.byte_address = 32'(record_start + ADDR_BITS'(data_index));
              result_next.byte_value   = rx_byte;
              result_next.record_kind  = '0;
              result_next.status       = STATUS_OK;
            end
          end else begin
            field_checksum_next = rx_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_address <= MAX_RECORD_ADDRESS_RESET;
      address_pointer    <= '0;
      record_start       <= '0;
      char_count         <= '0;
      prefix_done        <= 1'b0;
      nibble_hold        <= '0;
      field_count        <= '0;
      field_address      <= '0;
      field_type         <= '0;
      field_checksum     <= '0;
      data_index         <= '0;
      extended_value     <= '0;
      running_sum        <= '0;
      bad_field_flags    <= '0;
      result_valid       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_MAX_RECORD_ADDRESS) begin
        max_record_address <= pwdata[15:0];
      end
      address_pointer <= address_pointer_next;
      record_start    <= record_start_next;
      char_count      <= char_count_next;
      prefix_done     <= prefix_done_next;
      nibble_hold     <= nibble_hold_next;
      field_count     <= field_count_next;
      field_address   <= field_address_next;
      field_type      <= field_type_next;
      field_checksum  <= field_checksum_next;
      data_index      <= data_index_next;
      extended_value  <= extended_value_next;
      running_sum     <= running_sum_next;
      bad_field_flags <= bad_field_flags_next;
      if (accept) begin
        result_valid <= emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload register; loaded whenever a new item is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_item <= result_next;
    end
  end

endmodule

`default_nettype wire

### sim/intel_hex_record_parser_checker.sv
// Line parser model and result comparison for the Intel HEX record parser testbench.
`timescale 1ns / 1ps

module intel_hex_record_parser_checker
  import ihex_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  input  logic               char_ready,
  input  char_item_t         char_item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_item_t       result_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 results_owed
);

  // Parser state as the block should hold it.
  logic [15:0]          max_offset;
  logic [ADDR_BITS-1:0] load_ptr;
  logic [ADDR_BITS-1:0] rec_base;
  logic [9:0]           body_len;
  logic                 in_body;
  logic [3:0]           high_nibble;
  logic [7:0]           rec_len;
  logic [15:0]          rec_offset;
  logic [7:0]           rec_type;
  logic [7:0]           rec_sum_byte;
  logic [7:0]           data_pos;
  logic [31:0]          ext_shift;
  logic [7:0]           byte_sum;
  logic [4:0]           bad_fields;

  result_item_t parsed_results[$];
  result_item_t want;
  int           fail_total = 0;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void reset_line();
    body_len = '0;
    in_body = 1'b0;
    high_nibble = '0;
    rec_len = '0;
    rec_offset = '0;
    rec_type = '0;
    rec_sum_byte = '0;
    data_pos = '0;
    ext_shift = '0;
    byte_sum = '0;
    bad_fields = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int pos;
    int fld;
    int last;
    int flag;
    logic [4:0] dv;
    logic [3:0] nib;
    logic [7:0] b;
    logic [ADDR_BITS-1:0] at;
    logic [63:0] wide;
    result_item_t r;
    if (!in_body) begin
      if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_COLON) return;
      in_body = 1'b1;
    end
    pos = int'(body_len);
    if (body_len < CHAR_COUNT_MAX) body_len = body_len + 10'd1;
    fld = pos / 2;
    last = 4 + int'(rec_len);
    if (fld > last) return;
    if (fld == 0) flag = BAD_COUNT;
    else if (fld <= 2) flag = BAD_ADDR;
    else if (fld == 3) flag = BAD_TYPE;
    else if (fld < last) flag = BAD_DATA;
    else flag = BAD_CHK;
    dv = nibble_of(c);
    nib = dv[3:0];
    if (dv[4]) begin
      bad_fields[flag] = 1'b1;
      nib = 4'h0;
    end
    if (pos % 2 == 0) begin
      high_nibble = nib;
      return;
    end
    b = {high_nibble, nib};
    if (flag != BAD_CHK) byte_sum = byte_sum + b;
    if (fld == 0) begin
      rec_len = b;
    end else if (fld <= 2) begin
      rec_offset = {rec_offset[7:0], b};
      if (fld == 2) rec_base = {load_ptr[ADDR_BITS-1:16], rec_offset};
    end else if (fld == 3) begin
      rec_type = b;
    end else if (flag == BAD_DATA) begin
      at = rec_base + ADDR_BITS'(data_pos);
      data_pos = data_pos + 8'd1;
      ext_shift = {ext_shift[23:0], b};
      if (rec_type == REC_DATA) begin
        wide = 64'(at);
        r.kind = KIND_DATA;
        r.byte_address = wide[31:0];
        r.byte_value = b;
        r.record_kind = 8'h00;
        r.status = STATUS_OK;
        r.checksum_matches = 1'b0;
        parsed_results.insert(parsed_results.size(), r);
      end
    end else begin
      rec_sum_byte = b;
    end
  endfunction

  function automatic void close_record();
    int full;
    logic [ADDR_BITS-1:0] shown;
    logic [ADDR_BITS:0] advanced;
    logic [63:0] wide;
    status_t st;
    logic sum_ok;
    result_item_t r;
    full = 2 * int'(rec_len) + 10;
    sum_ok = (int'(body_len) >= full) && (8'(byte_sum + rec_sum_byte) == 8'h00);
    shown = load_ptr;
    st = STATUS_OK;
    if (body_len < HEADER_CHARS || bad_fields[BAD_ADDR]) begin
      st = STATUS_MALFORMED;
    end else begin
      load_ptr = rec_base;
      shown = load_ptr;
      if (bad_fields[BAD_COUNT] || int'(body_len) < full) begin
        st = STATUS_MALFORMED;
      end else if (rec_offset > max_offset) begin
        st = STATUS_JUMP;
      end else if (bad_fields[BAD_TYPE] || bad_fields[BAD_DATA] || bad_fields[BAD_CHK]) begin
        st = STATUS_MALFORMED;
      end else if (rec_type == REC_EXT_SEGMENT) begin
        wide = {32'd0, ext_shift} << 4;
        load_ptr = wide[ADDR_BITS-1:0];
      end else if (rec_type == REC_EXT_LINEAR) begin
        wide = {32'd0, ext_shift} << 16;
        load_ptr = wide[ADDR_BITS-1:0];
      end else begin
        // Any other type moves past its data; a carry out means the pointer wrapped.
        advanced = {1'b0, load_ptr} + (ADDR_BITS + 1)'(rec_len);
        if (advanced[ADDR_BITS]) st = STATUS_OVERFLOW;
        else load_ptr = advanced[ADDR_BITS-1:0];
      end
    end
    wide = 64'(shown);
    r.kind = KIND_STATUS;
    r.byte_address = wide[31:0];
    r.byte_value = 8'h00;
    r.record_kind = rec_type;
    r.status = st;
    r.checksum_matches = sum_ok;
    parsed_results.insert(parsed_results.size(), r);
    reset_line();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      max_offset <= MAX_RECORD_ADDRESS_RESET;
      load_ptr = '0;
      rec_base = '0;
      reset_line();
      parsed_results.delete();
      results_owed <= 0;
      mismatches <= fail_total;
    end else begin
      if (result_valid && result_ready) begin
        if (parsed_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result with none pending: kind=%0d addr=%h value=%h type=%h st=%0d ck=%0d",
                     $time, result_item.kind, result_item.byte_address, result_item.byte_value,
                     result_item.record_kind, result_item.status, result_item.checksum_matches);
        end else begin
          want = parsed_results.pop_front();
          if (result_item !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display({"%0t: mismatch: expected kind=%0d addr=%h value=%h type=%h st=%0d ck=%0d,",
                        " got kind=%0d addr=%h value=%h type=%h st=%0d ck=%0d"}, $time,
                       want.kind, want.byte_address, want.byte_value, want.record_kind,
                       want.status, want.checksum_matches,
                       result_item.kind, result_item.byte_address, result_item.byte_value,
                       result_item.record_kind, result_item.status, result_item.checksum_matches);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_MAX_RECORD_ADDRESS)
        max_offset <= pwdata[15:0];
      if (char_valid && char_ready) begin
        if (char_item.end_of_line) close_record();
        else parse_char(char_item.character);
      end
      results_owed <= parsed_results.size();
      mismatches <= fail_total;
    end
  end

endmodule

### sim/intel_hex_record_parser_tb.sv
// Testbench top for the Intel HEX record parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module intel_hex_record_parser_tb;
  import ihex_pkg::*;

  // Share of cycles in which each side holds off while idling is on.
  localparam int STALL_PERCENT = 31;
  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Characters sent in the random part, spread over the register settings.
  localparam int RANDOM_CHARS = 600;

  logic               clk;
  logic               rst;
  logic               char_valid;
  logic               char_ready;
  char_item_t         char_item;
  logic               result_valid;
  logic               result_ready;
  result_item_t       result_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int results_owed;
  int quiet_cycles;
  int chars_sent;
  bit gaps_enabled;

  // Characters of the line being built, and the data bytes of the record in it.
  logic [7:0]  line_text[$];
  logic [7:0]  payload[$];
  logic [15:0] max_addr_setting;

  intel_hex_record_parser u_dut (.*);

  intel_hex_record_parser_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls on its own schedule, independent of the character side.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= !gaps_enabled || ($urandom_range(99) >= STALL_PERCENT);
  end

  // Watchdog: a run that stops moving items is a hang, not a slow pass.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("intel_hex_record_parser_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hex digit with a random letter case, since the block must take both.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    line_text.insert(line_text.size(), hex_digit(b[7:4]));
    line_text.insert(line_text.size(), hex_digit(b[3:0]));
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    return c;
  endfunction

  // Appends the body of a record built from payload; a bad sum is off by one.
  function automatic void add_record(input logic [7:0] rtype, input logic [15:0] raddr,
                                     input bit good_sum);
    logic [7:0] total;
    total = 8'(payload.size()) + raddr[15:8] + raddr[7:0] + rtype;
    add_byte(8'(payload.size()));
    add_byte(raddr[15:8]);
    add_byte(raddr[7:0]);
    add_byte(rtype);
    foreach (payload[i]) begin
      add_byte(payload[i]);
      total = total + payload[i];
    end
    add_byte(good_sum ? 8'(-total) : ~total);
  endfunction

  // A well-formed line with random content. Addresses cluster at the top of the
  // 64 KiB window, near zero and around the current limit, and linear extended
  // records often carry all ones, so jumps and pointer wraps happen often.
  function automatic void random_record_line();
    int pick;
    int n;
    logic [7:0] rtype;
    logic [15:0] raddr;
    payload.delete();
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(2);
      line_text.insert(line_text.size(),
                       pick == 0 ? CHAR_SPACE : (pick == 1 ? CHAR_TAB : CHAR_COLON));
    end
    pick = $urandom_range(99);
    if (pick < 55) rtype = REC_DATA;
    else if (pick < 67) rtype = REC_EXT_SEGMENT;
    else if (pick < 82) rtype = REC_EXT_LINEAR;
    else if (pick < 92) rtype = 8'h01;
    else rtype = 8'($urandom);
    if (rtype == REC_EXT_SEGMENT || rtype == REC_EXT_LINEAR)
      n = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 2;
    else if ($urandom_range(39) == 0)
      n = $urandom_range(16, 60);
    else
      n = $urandom_range(0, 8);
    case ($urandom_range(3))
      0: raddr = 16'($urandom);
      1: raddr = 16'hFFFF - 16'($urandom_range(0, 15));
      2: raddr = 16'($urandom_range(0, 31));
      default: raddr = max_addr_setting + 16'($urandom_range(0, 2)) - 16'd1;
    endcase
    for (int i = 0; i < n; i++)
      payload.insert(payload.size(),
                     (rtype == REC_EXT_LINEAR && $urandom_range(1)) ? 8'hFF : 8'($urandom));
    add_record(rtype, raddr, $urandom_range(9) != 0);
    // Now and then junk after the checksum, which the block must ignore.
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 4)) line_text.insert(line_text.size(), 8'($urandom));
  endfunction

  // Noise, cut-off records and records with a bad character somewhere.
  function automatic void broken_line();
    int pick;
    int cut;
    pick = $urandom_range(3);
    if (pick == 0) begin
      repeat ($urandom_range(0, 24)) line_text.insert(line_text.size(), 8'($urandom));
    end else begin
      random_record_line();
      if (pick == 1) begin
        cut = $urandom_range(0, line_text.size() - 1);
        while (line_text.size() > cut) line_text.delete(line_text.size() - 1);
      end else if (pick == 2) begin
        line_text[$urandom_range(0, line_text.size() - 1)] = non_hex_char();
      end else begin
        line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom);
      end
    end
  endfunction

  // Offers one item and returns at the edge where it is taken. The valid stays
  // high into the next call unless idle cycles are drawn, one at a time.
  task automatic send_item(input logic [7:0] c, input logic eol);
    while (gaps_enabled && $urandom_range(99) < STALL_PERCENT) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item.character <= c;
    char_item.end_of_line <= eol;
    do @(posedge clk); while (!char_ready);
    chars_sent++;
  endtask

  // Sends the built line and closes it with a terminator carrying a junk character.
  task automatic send_line();
    foreach (line_text[i]) send_item(line_text[i], 1'b0);
    send_item(8'($urandom), 1'b1);
    line_text.delete();
  endtask

  // Stops sending and waits until every predicted result has come out. The extra
  // cycles cover a character still in flight that causes no result.
  task automatic drain();
    char_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_addr_setting = d[15:0];
  endtask

  initial begin
    int bad_pos[5];
    logic [15:0] max_settings[4];
    int phase_end;

    rst <= 1'b1;
    char_valid <= 1'b0;
    char_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    gaps_enabled = 1'b1;
    chars_sent = 0;
    max_addr_setting = MAX_RECORD_ADDRESS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A bare terminator, then a line that is nothing but skipped prefix.
    send_line();
    line_text = '{CHAR_SPACE, CHAR_TAB, CHAR_COLON};
    send_line();
    // A body of four characters, far too short for a header.
    line_text = '{8'h30, 8'h31, 8'h30, 8'h30};
    send_line();
    // An ordinary data record under the reset limit.
    payload = '{8'h11, 8'h22, 8'h33};
    add_record(REC_DATA, 16'h0010, 1'b1);
    send_line();
    // Linear extended address of all ones moves the pointer to the top window.
    payload = '{8'hFF, 8'hFF};
    add_record(REC_EXT_LINEAR, 16'h0000, 1'b1);
    send_line();
    // Data that runs off the top of the address space: the bytes still come out,
    // their addresses wrap, and the status reports the overflow.
    payload = '{8'hA5, 8'h5A, 8'hFF, 8'h00};
    add_record(REC_DATA, 16'hFFFE, 1'b1);
    send_line();
    // Empty record at the highest address with a wrong checksum; still accepted.
    payload.delete();
    add_record(REC_DATA, 16'hFFFF, 1'b0);
    send_line();
    // Segment extended address.
    payload = '{8'h12, 8'h34};
    add_record(REC_EXT_SEGMENT, 16'h0000, 1'b1);
    send_line();
    // End-of-file record followed by trailing junk.
    payload.delete();
    add_record(8'h01, 16'h0000, 1'b1);
    line_text.insert(line_text.size(), 8'h5A);
    line_text.insert(line_text.size(), 8'hFF);
    send_line();
    // A non-hex character in the count, address, type, data and checksum fields.
    bad_pos = '{1, 4, 7, 9, 13};
    foreach (bad_pos[f]) begin
      payload = '{8'hC3, 8'h3C};
      add_record(REC_DATA, 16'h0100, 1'b1);
      line_text[bad_pos[f]] = non_hex_char();
      send_line();
    end
    // Count says four bytes but only three arrive before the terminator.
    payload = '{8'h01, 8'h02, 8'h03, 8'h04};
    add_record(REC_DATA, 16'h0200, 1'b1);
    while (line_text.size() > 14) line_text.delete(line_text.size() - 1);
    send_line();

    // With the lowest limit, any nonzero record address is a jump.
    drain();
    apb_write(REG_MAX_RECORD_ADDRESS, PDATA_W'(16'h0000));
    payload = '{8'h77};
    add_record(REC_DATA, 16'h0001, 1'b1);
    send_line();
    payload = '{8'h88};
    add_record(REC_DATA, 16'h0000, 1'b1);
    send_line();
    // The largest count with only three data bytes behind it: the line is short.
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(REC_DATA);
    repeat (3) add_byte(8'($urandom));
    send_line();

    // Random part over several limits, both extremes included. The second
    // setting runs with no idling on either side.
    max_settings = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000};
    max_settings[3] = 16'($urandom);
    foreach (max_settings[p]) begin
      drain();
      apb_write(REG_MAX_RECORD_ADDRESS, PDATA_W'(max_settings[p]));
      gaps_enabled = (p != 1);
      phase_end = chars_sent + RANDOM_CHARS / 4;
      while (chars_sent < phase_end) begin
        if ($urandom_range(99) < 80) random_record_line();
        else broken_line();
        send_line();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("intel_hex_record_parser_tb passed");
    end else begin
      $display("intel_hex_record_parser_tb failed");
    end
    $finish;
  end

endmodule
